### sv/mrfr_pkg.sv
`timescale 1ns / 1ps

package mrfr_pkg;

   // frame geometry
   localparam int FRAME_BYTES = 8;
   localparam int CRC_SPAN    = 6;
   localparam int IDX_W       = $clog2(FRAME_BYTES);

   // CRC-16, reflected form
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // reset value of the timeout register
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // register file
   localparam int          CSR_ADDR_W      = 3;
   localparam logic [0:0]  CSR_IDX_TIMEOUT = 1'b0;

   // input word opcodes
   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // receiver phase, one-hot
   typedef enum logic [2:0] {
      PH_STANDBY = 3'b001,
      PH_RECEIVE = 3'b010,
      PH_WAIT    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic        frame_done;
      logic [7:0]  gateway_id;
      logic [7:0]  function_code;
      logic [15:0] group_id;
      logic [15:0] data_word;
      logic [15:0] last_crc;
   } rsp_word_type;

   // one byte through the CRC-16 shift register
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### sv/modbus_rtu_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Modbus RTU style receiver for fixed 8-byte frames. Each input word is a
// received byte, a timer tick, a clear of the done flag or a no-op, and each gives
// exactly one output word with the current decoded state. A word is taken
// every cycle unless the output stalls; it is held in the input register and
// its result is then registered in the output register. The per-word work
// (one byte through the CRC-16, the frame check and the timer) is a single
// combinational pass between those two registers. The timeout register
// (byte address 0) reloads the inter-byte timer on each frame byte; once it
// runs down to zero the next byte starts a new frame.
module modbus_rtu_frame_receiver_unit
   import mrfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // register port
   logic [15:0] timeout_ff, timeout_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_write && paddr[CSR_ADDR_W-1] == CSR_IDX_TIMEOUT) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1])
         CSR_IDX_TIMEOUT: prdata = {16'h0000, timeout_ff};
         default:         prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // handshake: input register feeds output register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         req_accept, advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // receiver state
   phase_type        phase_ff, phase_in, phase_eff;
   logic [IDX_W-1:0] count_ff, count_in, count_eff;
   logic [15:0]      ticks_ff, ticks_in;
   logic [15:0]      crc_ff, crc_in;
   logic             done_ff, done_in;
   logic [7:0]       gateway_ff, gateway_in;
   logic [7:0]       function_ff, function_in;
   logic [15:0]      group_ff, group_in;
   logic [15:0]      data_ff, data_in;
   logic [15:0]      crc_latched_ff, crc_latched_in;
   logic [7:0]       frame_ff [FRAME_BYTES];
   logic             store_en;
   logic [15:0]      crc_upd, rx_crc;
   logic [7:0]       b;
   opcode_type       op;

   assign b  = in_word_ff.rx_byte;
   assign op = opcode_type'(in_word_ff.opcode);

   // timeout expired: fall back to standby before looking at the byte
   assign phase_eff = (ticks_ff == 16'h0000) ? PH_STANDBY : phase_ff;
   assign count_eff = (ticks_ff == 16'h0000) ? '0 : count_ff;

   assign crc_upd = crc16_byte((phase_eff == PH_STANDBY) ? CRC_INIT : crc_ff, b);
   assign rx_crc  = {b, frame_ff[CRC_SPAN]};

   // next state for one word
   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      ticks_in       = ticks_ff;
      crc_in         = crc_ff;
      done_in        = done_ff;
      gateway_in     = gateway_ff;
      function_in    = function_ff;
      group_in       = group_ff;
      data_in        = data_ff;
      crc_latched_in = crc_latched_ff;
      store_en       = 1'b0;
      case (op)
         OP_BYTE: begin
            unique case (phase_eff)
               PH_STANDBY: begin
                  store_en = 1'b1;
                  crc_in   = crc_upd;
                  count_in = IDX_W'(1);
                  ticks_in = timeout_ff;
                  done_in  = 1'b0;
                  phase_in = PH_RECEIVE;
               end
               PH_RECEIVE: begin
                  store_en = 1'b1;
                  ticks_in = timeout_ff;
                  count_in = count_eff + IDX_W'(1);
                  if (count_eff < IDX_W'(CRC_SPAN)) begin
                     crc_in = crc_upd;
                  end
                  // last byte: check and latch
                  if (count_eff == IDX_W'(FRAME_BYTES - 1)) begin
                     crc_latched_in = crc_ff;
                     phase_in       = PH_WAIT;
                     if (crc_ff == rx_crc) begin
                        gateway_in  = frame_ff[0];
                        function_in = frame_ff[1];
                        group_in    = {frame_ff[2], frame_ff[3]};
                        data_in     = {frame_ff[4], frame_ff[5]};
                        done_in     = 1'b1;
                     end else begin
                        done_in = 1'b0;
                     end
                  end
               end
               default: begin
                  // waiting: byte dropped, timer left running
                  phase_in = phase_eff;
                  count_in = '0;
               end
            endcase
         end
         OP_TICK: begin
            if (ticks_ff != 16'h0000) begin
               ticks_in = ticks_ff - 16'd1;
            end
         end
         OP_CLEAR: done_in = 1'b0;
         default: ;
      endcase
   end

   always_comb begin
      rsp_word_in.frame_done    = done_in;
      rsp_word_in.gateway_id    = gateway_in;
      rsp_word_in.function_code = function_in;
      rsp_word_in.group_id      = group_in;
      rsp_word_in.data_word     = data_in;
      rsp_word_in.last_crc      = crc_latched_in;
   end

   // control and visible state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_STANDBY;
         count_ff       <= '0;
         ticks_ff       <= 16'h0000;
         crc_ff         <= CRC_INIT;
         done_ff        <= 1'b0;
         gateway_ff     <= 8'h00;
         function_ff    <= 8'h00;
         group_ff       <= 16'h0000;
         data_ff        <= 16'h0000;
         crc_latched_ff <= 16'h0000;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            count_ff       <= count_in;
            ticks_ff       <= ticks_in;
            crc_ff         <= crc_in;
            done_ff        <= done_in;
            gateway_ff     <= gateway_in;
            function_ff    <= function_in;
            group_ff       <= group_in;
            data_ff        <= data_in;
            crc_latched_ff <= crc_latched_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (advance && store_en) begin
         frame_ff[count_eff] <= b;
      end
   end

   // checks
   a_advance_gives_word: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word did not reach the output register");

   a_held_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("input word lost while output stalled");

   a_done_from_frame: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(done_ff)) |-> ($past(phase_ff) == PH_RECEIVE))
      else $error("done set outside a frame");

   a_crc_latched_on_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(crc_latched_ff)) |-> (phase_ff == PH_WAIT))
      else $error("last CRC changed without a completed frame");

endmodule
